>>> sv/ows_pkg.sv
package ows_pkg;

  localparam int unsigned COUNT_W = 7;
  localparam logic [COUNT_W-1:0] MAX_DEVICES_RST = 7'd64;

  // Dallas/Maxim CRC-8, reflected form of x^8 + x^5 + x^4 + 1
  localparam logic [7:0] CRC8_POLY = 8'h8C;

  localparam logic MODE_NEW_SEARCH = 1'b0;
  localparam logic MODE_BIT_PAIR   = 1'b1;

  typedef struct packed {
    logic               direction_bit;
    logic               pass_done;
    logic               crc_ok;
    logic               more_devices;
    logic               no_response;
    logic [COUNT_W-1:0] found_count;
  } res_t;

  function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic data_bit);
    logic       fb;
    logic [7:0] sh;
    fb = crc[0] ^ data_bit;
    sh = {1'b0, crc[7:1]};
    return fb ? (sh ^ CRC8_POLY) : sh;
  endfunction

endpackage

>>> sv/ows_engine.sv
// Search state and branch decision. The result for the item on the inputs is
// combinational; the state moves on at the edge where fire is high.
module ows_engine #(
  parameter int unsigned CODE_BITS    = 64,
  parameter int unsigned DEVICE_LIMIT = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic                             mode,
  input  logic                             id_bit,
  input  logic                             complement_bit,
  input  logic [ows_pkg::COUNT_W-1:0]      max_devices,
  output ows_pkg::res_t                    res,
  output logic [CODE_BITS-1:0]             rom_code
);

  localparam int unsigned IDX_W = $clog2(CODE_BITS);
  localparam int unsigned POS_W = $clog2(CODE_BITS + 1);
  localparam int unsigned CW    = ows_pkg::COUNT_W;

  logic [CODE_BITS-1:0] prev_code_r, prev_code_nxt;
  logic [CODE_BITS-1:0] cur_code_r, cur_code_nxt;
  logic [POS_W-1:0]     last_disc_r, last_disc_nxt;
  logic [POS_W-1:0]     last_zero_r, last_zero_nxt;
  logic [IDX_W-1:0]     bit_idx_r, bit_idx_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic                 finished_r, finished_nxt;

  logic [CW-1:0]        limit;
  logic                 stopped;
  logic                 conflict;
  logic [POS_W-1:0]     pos;
  logic                 dir;
  logic [CODE_BITS-1:0] code_bit;
  logic [7:0]           crc_upd;
  logic                 last_bit;
  logic [CW-1:0]        total_inc;
  logic [POS_W-1:0]     lz_upd;
  logic                 more;

  assign limit    = (max_devices > CW'(DEVICE_LIMIT)) ? CW'(DEVICE_LIMIT) : max_devices;
  assign stopped  = finished_r || (total_r >= limit);
  assign conflict = (id_bit == complement_bit);
  assign pos      = POS_W'(bit_idx_r) + POS_W'(1);
  assign last_bit = (bit_idx_r == IDX_W'(CODE_BITS - 1));

  always_comb begin
    priority if (!conflict) begin
      dir = id_bit;
    end else if (pos < last_disc_r) begin
      dir = prev_code_r[bit_idx_r];
    end else if (pos == last_disc_r) begin
      dir = 1'b1;
    end else begin
      dir = 1'b0;
    end
  end

  always_comb begin
    code_bit            = '0;
    code_bit[bit_idx_r] = dir;
  end

  assign crc_upd   = ows_pkg::crc8_bit(crc_r, dir);
  assign total_inc = total_r + CW'(1);
  // a conflict resolved to 0 is the newest branch still to explore
  assign lz_upd    = (conflict && !dir) ? pos : last_zero_r;
  assign more      = (lz_upd != '0) && (total_inc < limit);

  always_comb begin
    res           = '0;
    rom_code      = '0;
    prev_code_nxt = prev_code_r;
    cur_code_nxt  = cur_code_r;
    last_disc_nxt = last_disc_r;
    last_zero_nxt = last_zero_r;
    bit_idx_nxt   = bit_idx_r;
    total_nxt     = total_r;
    crc_nxt       = crc_r;
    finished_nxt  = finished_r;
    priority if (mode == ows_pkg::MODE_NEW_SEARCH) begin
      prev_code_nxt = '0;
      cur_code_nxt  = '0;
      last_disc_nxt = '0;
      last_zero_nxt = '0;
      bit_idx_nxt   = '0;
      total_nxt     = '0;
      crc_nxt       = '0;
      finished_nxt  = 1'b0;
    end else if (stopped) begin
      res.found_count = total_r;
    end else if (id_bit && complement_bit) begin
      // nobody answered: restart the pass, keep the search history
      res.no_response = 1'b1;
      res.found_count = total_r;
      cur_code_nxt    = '0;
      last_zero_nxt   = '0;
      bit_idx_nxt     = '0;
      crc_nxt         = '0;
    end else begin
      res.direction_bit = dir;
      if (last_bit) begin
        res.pass_done    = 1'b1;
        res.crc_ok       = (crc_upd == 8'h00);
        res.more_devices = more;
        res.found_count  = total_inc;
        rom_code         = cur_code_r | code_bit;
        prev_code_nxt    = cur_code_r | code_bit;
        last_disc_nxt    = lz_upd;
        total_nxt        = total_inc;
        finished_nxt     = !more;
        cur_code_nxt     = '0;
        last_zero_nxt    = '0;
        bit_idx_nxt      = '0;
        crc_nxt          = '0;
      end else begin
        res.found_count = total_r;
        cur_code_nxt    = cur_code_r | code_bit;
        last_zero_nxt   = lz_upd;
        bit_idx_nxt     = bit_idx_r + IDX_W'(1);
        crc_nxt         = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_code_r <= '0;
      cur_code_r  <= '0;
      last_disc_r <= '0;
      last_zero_r <= '0;
      bit_idx_r   <= '0;
      total_r     <= '0;
      crc_r       <= '0;
      finished_r  <= 1'b0;
    end else if (fire) begin
      prev_code_r <= prev_code_nxt;
      cur_code_r  <= cur_code_nxt;
      last_disc_r <= last_disc_nxt;
      last_zero_r <= last_zero_nxt;
      bit_idx_r   <= bit_idx_nxt;
      total_r     <= total_nxt;
      crc_r       <= crc_nxt;
      finished_r  <= finished_nxt;
    end
  end

endmodule

>>> sv/onewire_rom_search.sv
// 1-Wire search-ROM engine. Each item is either a new-search command (mode 0)
// or one id/complement bit pair read from the bus, and each item gives exactly
// one result with the direction bit to write back. The pair that completes a
// code also carries the code, its CRC-8 check, the running device count and a
// flag saying whether another pass is worth running. An item passes through an
// input register and a result register; one item is taken every cycle while
// out_stall does not hold the result register. The loop through the search
// state (branch decision, code bit, CRC step) closes combinationally into the
// state registers. max_devices may only be written while no item is in flight.
module onewire_rom_search #(
  parameter int unsigned CODE_BITS    = 64,
  parameter int unsigned DEVICE_LIMIT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        cfg_we,
  input  logic [ows_pkg::COUNT_W-1:0] cfg_wdata,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic                        in_id_bit,
  input  logic                        in_complement_bit,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_direction_bit,
  output logic                        out_pass_done,
  output logic [CODE_BITS-1:0]        out_rom_code,
  output logic                        out_crc_ok,
  output logic                        out_more_devices,
  output logic                        out_no_response,
  output logic [ows_pkg::COUNT_W-1:0] out_found_count
);

  logic [ows_pkg::COUNT_W-1:0] max_dev_r;

  logic           s1_valid_r;
  logic           s1_mode_r;
  logic           s1_id_r;
  logic           s1_comp_r;

  logic           out_valid_r;
  ows_pkg::res_t  out_res_r;
  logic [CODE_BITS-1:0] out_code_r;

  logic           adv;
  logic           accept;
  ows_pkg::res_t  eng_res;
  logic [CODE_BITS-1:0] eng_code;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dev_r <= ows_pkg::MAX_DEVICES_RST;
    end else if (cfg_we) begin
      max_dev_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= in_mode;
      s1_id_r   <= in_id_bit;
      s1_comp_r <= in_complement_bit;
    end
  end

  ows_engine #(
    .CODE_BITS    (CODE_BITS),
    .DEVICE_LIMIT (DEVICE_LIMIT)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (adv),
    .mode           (s1_mode_r),
    .id_bit         (s1_id_r),
    .complement_bit (s1_comp_r),
    .max_devices    (max_dev_r),
    .res            (eng_res),
    .rom_code       (eng_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r  <= eng_res;
      out_code_r <= eng_code;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_direction_bit = out_res_r.direction_bit;
  assign out_pass_done     = out_res_r.pass_done;
  assign out_rom_code      = out_code_r;
  assign out_crc_ok        = out_res_r.crc_ok;
  assign out_more_devices  = out_res_r.more_devices;
  assign out_no_response   = out_res_r.no_response;
  assign out_found_count   = out_res_r.found_count;

  // a finished item always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("item left input register without reaching result register");

  a_abort_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.no_response && out_res_r.pass_done))
    else $error("result both aborted and completed");

  a_abort_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.no_response) |-> !out_res_r.direction_bit)
    else $error("direction bit set on aborted pair");

  a_more_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.pass_done) |->
      (!out_res_r.more_devices && !out_res_r.crc_ok && out_code_r == '0))
    else $error("pass results shown without a completed code");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.pass_done) |->
      (out_res_r.found_count != '0 &&
       out_res_r.found_count <= ows_pkg::COUNT_W'(DEVICE_LIMIT)))
    else $error("device count out of range on completed pass");

endmodule

>>> tb/tb_onewire_rom_search.sv
`timescale 1ns / 100ps

module tb_onewire_rom_search;

  localparam int unsigned CODE_W = 64;
  localparam logic [ows_pkg::COUNT_W-1:0] DEV_LIMIT = 7'd64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned STAGES = 6;
  localparam int unsigned STAGE_ITEMS = 240;

  typedef struct packed {
    logic mode;
    logic id_b;
    logic cmp_b;
  } bus_item_t;

  typedef struct packed {
    logic                        direction;
    logic                        done;
    logic [CODE_W-1:0]           code;
    logic                        crc_ok;
    logic                        more;
    logic                        no_resp;
    logic [ows_pkg::COUNT_W-1:0] count;
  } search_result_t;

  typedef struct packed {
    logic [CODE_W-1:0]           prev_code;
    logic [CODE_W-1:0]           cur_code;
    logic [ows_pkg::COUNT_W-1:0] last_disc;
    logic [ows_pkg::COUNT_W-1:0] last_zero;
    logic [5:0]                  bit_idx;
    logic [ows_pkg::COUNT_W-1:0] dev_total;
    logic [7:0]                  crc;
    logic                        finished;
    logic [ows_pkg::COUNT_W-1:0] max_dev;
  } search_state_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [ows_pkg::COUNT_W-1:0]   cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_mode = ows_pkg::MODE_NEW_SEARCH;
  logic                          in_id_bit = 1'b0;
  logic                          in_complement_bit = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_direction_bit;
  logic                          out_pass_done;
  logic [CODE_W-1:0]             out_rom_code;
  logic                          out_crc_ok;
  logic                          out_more_devices;
  logic                          out_no_response;
  logic [ows_pkg::COUNT_W-1:0]   out_found_count;

  bus_item_t      pending_q[$];
  search_result_t expected_q[$];
  search_state_t  pred_st;   // tracks what the block has accepted
  search_state_t  plan_st;   // tracks what has been queued, steers the device model
  int             err_count = 0;
  int             gen_count = 0;
  int             stage_end = 0;
  int             cycle_count = 0;
  int             send_gap_pct = 0;
  int             recv_stall_pct = 0;

  onewire_rom_search u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_id_bit         (in_id_bit),
    .in_complement_bit (in_complement_bit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_direction_bit (out_direction_bit),
    .out_pass_done     (out_pass_done),
    .out_rom_code      (out_rom_code),
    .out_crc_ok        (out_crc_ok),
    .out_more_devices  (out_more_devices),
    .out_no_response   (out_no_response),
    .out_found_count   (out_found_count)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic data_bit);
    logic fb;
    fb = crc[0] ^ data_bit;
    return {1'b0, crc[7:1]} ^ (fb ? ows_pkg::CRC8_POLY : 8'h00);
  endfunction

  function automatic void clear_pass(inout search_state_t st);
    st.cur_code  = '0;
    st.last_zero = '0;
    st.bit_idx   = '0;
    st.crc       = '0;
  endfunction

  function automatic void clear_search(inout search_state_t st);
    clear_pass(st);
    st.prev_code = '0;
    st.last_disc = '0;
    st.dev_total = '0;
    st.finished  = 1'b0;
  endfunction

  function automatic logic [ows_pkg::COUNT_W-1:0] eff_limit(input search_state_t st);
    return (st.max_dev > DEV_LIMIT) ? DEV_LIMIT : st.max_dev;
  endfunction

  function automatic search_result_t search_step(inout search_state_t st, input logic mode,
                                                 input logic id_b, input logic cmp_b);
    search_result_t              r;
    logic [ows_pkg::COUNT_W-1:0] pos;
    logic                        dir;
    r = '0;
    if (mode == ows_pkg::MODE_NEW_SEARCH) begin
      clear_search(st);
    end else if (st.finished || st.dev_total >= eff_limit(st)) begin
      r.count = st.dev_total;
    end else if (id_b && cmp_b) begin
      clear_pass(st);
      r.no_resp = 1'b1;
      r.count   = st.dev_total;
    end else begin
      pos = {1'b0, st.bit_idx} + 7'd1;
      if (id_b != cmp_b) begin
        dir = id_b;
      end else begin
        // conflict: replay below the last discrepancy, branch to 1 at it, 0 above
        if (pos < st.last_disc) dir = st.prev_code[st.bit_idx];
        else if (pos == st.last_disc) dir = 1'b1;
        else dir = 1'b0;
        if (!dir) st.last_zero = pos;
      end
      st.cur_code[st.bit_idx] = st.cur_code[st.bit_idx] | dir;
      st.crc = crc8_step(st.crc, dir);
      r.direction = dir;
      if (pos >= CODE_W) begin
        r.done      = 1'b1;
        r.code      = st.cur_code;
        r.crc_ok    = (st.crc == 8'h00);
        st.prev_code = st.cur_code;
        st.last_disc = st.last_zero;
        st.dev_total = st.dev_total + 7'd1;
        r.more = (st.last_disc != 0) && (st.dev_total < eff_limit(st));
        if (!r.more) st.finished = 1'b1;
        clear_pass(st);
      end else begin
        st.bit_idx = st.bit_idx + 6'd1;
      end
      r.count = st.dev_total;
    end
    return r;
  endfunction

  function automatic search_result_t push_item(input logic mode, input logic id_b,
                                               input logic cmp_b);
    pending_q.push_back('{mode: mode, id_b: id_b, cmp_b: cmp_b});
    gen_count++;
    return search_step(plan_st, mode, id_b, cmp_b);
  endfunction

  function automatic logic [CODE_W-1:0] rom_with_crc(input logic [CODE_W-1:0] c);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < 56; i++) crc = crc8_step(crc, c[i]);
    return {crc, c[55:0]};
  endfunction

  // One search over a random family of devices, most of them near a shared base,
  // answering each bit slot as the wired-and bus would, but for rare random pairs and a rare abort.
  task automatic plan_search();
    logic [CODE_W-1:0] devs[$];
    bit                alive[$];
    logic [CODE_W-1:0] base;
    logic [CODE_W-1:0] code;
    search_result_t    r;
    logic              id_b;
    logic              cmp_b;
    int                n;
    int                passes;
    bit                pass_over;
    r = push_item(ows_pkg::MODE_NEW_SEARCH, 1'($urandom_range(1)), 1'($urandom_range(1)));
    case ($urandom_range(9))
      0: base = '0;
      1: base = '1;
      default: base = {$urandom, $urandom};
    endcase
    n = ($urandom_range(7) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
    for (int k = 0; k < n; k++) begin
      code = base;
      if ($urandom_range(5) == 0) code = {$urandom, $urandom};
      else for (int f = $urandom_range(1, 3); f > 0; f--)
        code[6'($urandom_range(55))] ^= 1'b1;
      if ($urandom_range(9) != 0) code = rom_with_crc(code);
      devs.push_back(code);
      alive.push_back(1'b1);
    end
    passes = 0;
    while (!plan_st.finished && plan_st.dev_total < eff_limit(plan_st) &&
           passes < 3 * n + 4 && gen_count < stage_end) begin
      passes++;
      foreach (alive[k]) alive[k] = 1'b1;
      pass_over = 1'b0;
      for (int i = 0; i < CODE_W && !pass_over && gen_count < stage_end; i++) begin
        id_b  = 1'b1;
        cmp_b = 1'b1;
        foreach (devs[k]) begin
          if (alive[k]) begin
            id_b  &= devs[k][i];
            cmp_b &= ~devs[k][i];
          end
        end
        if ($urandom_range(399) == 0) begin
          // abandon the search part way through
          r = push_item(ows_pkg::MODE_NEW_SEARCH, id_b, cmp_b);
          return;
        end
        if ($urandom_range(299) == 0) begin
          id_b  = 1'($urandom_range(1));
          cmp_b = 1'($urandom_range(1));
        end
        r = push_item(ows_pkg::MODE_BIT_PAIR, id_b, cmp_b);
        pass_over = r.done || r.no_resp;
        foreach (devs[k]) if (devs[k][i] != r.direction) alive[k] = 1'b0;
      end
    end
    // up to two pairs after the end of the search
    for (int k = $urandom_range(2); k > 0; k--)
      r = push_item(ows_pkg::MODE_BIT_PAIR, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [CODE_W-1:0] got,
                                 input logic [CODE_W-1:0] want);
    if (err_count < 40)
      $display("mismatch at cycle %0d on %s: got %0h, want %0h", cycle_count, field, got, want);
    err_count++;
  endtask

  // Input driver
  always @(posedge clk) begin : bus_driver
    bus_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        it = pending_q.pop_front();
        in_valid          <= 1'b1;
        in_mode           <= it.mode;
        in_id_bit         <= it.id_b;
        in_complement_bit <= it.cmp_b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: predict on acceptance, check on delivery
  always @(posedge clk) begin : result_monitor
    search_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_q.push_back(search_step(pred_st, in_mode, in_id_bit, in_complement_bit));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected item", out_rom_code, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_direction_bit !== want.direction)
            report_mismatch("direction_bit", CODE_W'(out_direction_bit),
                            CODE_W'(want.direction));
          if (out_pass_done !== want.done)
            report_mismatch("pass_done", CODE_W'(out_pass_done), CODE_W'(want.done));
          if (out_rom_code !== want.code)
            report_mismatch("rom_code", out_rom_code, want.code);
          if (out_crc_ok !== want.crc_ok)
            report_mismatch("crc_ok", CODE_W'(out_crc_ok), CODE_W'(want.crc_ok));
          if (out_more_devices !== want.more)
            report_mismatch("more_devices", CODE_W'(out_more_devices), CODE_W'(want.more));
          if (out_no_response !== want.no_resp)
            report_mismatch("no_response", CODE_W'(out_no_response), CODE_W'(want.no_resp));
          if (out_found_count !== want.count)
            report_mismatch("found_count", CODE_W'(out_found_count), CODE_W'(want.count));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ows_pkg::COUNT_W-1:0] stage_cfg [STAGES];
    stage_cfg = '{7'd1, 7'd64, 7'd3, 7'd2, 7'd64, 7'd1};
    stage_cfg[STAGES-1] = ows_pkg::COUNT_W'($urandom_range(1, 64));
    clear_search(pred_st);
    clear_search(plan_st);
    pred_st.max_dev = ows_pkg::MAX_DEVICES_RST;
    plan_st.max_dev = ows_pkg::MAX_DEVICES_RST;
    send_gap_pct   = 6;
    recv_stall_pct = 60;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: no-response at bit 0, plain pairs, conflicts, abort mid pass
    void'(push_item(ows_pkg::MODE_NEW_SEARCH, 1'b1, 1'b1));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b1, 1'b1));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b1, 1'b0));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b0, 1'b1));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b0, 1'b0));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b0, 1'b0));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b1, 1'b1));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b0, 1'b0));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b1, 1'b0));
    void'(push_item(ows_pkg::MODE_NEW_SEARCH, 1'b0, 1'b1));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b0, 1'b0));
    void'(push_item(ows_pkg::MODE_BIT_PAIR, 1'b0, 1'b1));
    void'(push_item(ows_pkg::MODE_NEW_SEARCH, 1'b1, 1'b0));

    for (int s = 0; s < STAGES; s++) begin
      wait_idle();
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= stage_cfg[s];
      @(posedge clk);
      cfg_we <= 1'b0;
      pred_st.max_dev = stage_cfg[s];
      plan_st.max_dev = stage_cfg[s];
      if (s < 2) begin
        send_gap_pct   = 6;
        recv_stall_pct = 60;
      end else if (s < 4) begin
        send_gap_pct   = 60;
        recv_stall_pct = 6;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      stage_end = gen_count + STAGE_ITEMS;
      while (gen_count < stage_end) plan_search();
    end

    wait_idle();
    if (err_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> onewire_rom_search.f
sv/ows_pkg.sv
sv/ows_engine.sv
sv/onewire_rom_search.sv
tb/tb_onewire_rom_search.sv
